@@ hw/rtl/nnot_pkg.sv @@
// Shared constants and types of the nearest-neighbour track table.
package nnot_pkg;

	localparam int MAX_TRACKS = 16;
	localparam int COORD_BITS = 18;

	localparam int SLOT_W  = $clog2(MAX_TRACKS);
	localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
	localparam int GATE_W  = 17;
	localparam int TIME_W  = 32;
	localparam int PTS_W   = 12;
	localparam int ID_W    = 16;
	localparam int CFG_W   = 32;
	localparam int MUL_W   = (COORD_BITS + 1 > GATE_W) ? COORD_BITS + 1 : GATE_W;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = PROD_W + 2;

	localparam logic [GATE_W-1:0] GATE_RST    = GATE_W'(5000);
	localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(5000);
	localparam logic [PTS_W-1:0]  MIN_PUB_RST = PTS_W'(10);

	typedef enum logic [1:0] {
		CFG_GATE    = 2'd0,
		CFG_TIMEOUT = 2'd1,
		CFG_MIN_PUB = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_CENTROID   = 2'd0,
		REQ_NO_CLUSTER = 2'd1,
		REQ_CLEANUP    = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		AS_MATCH = 2'd0,
		AS_NEW   = 2'd1,
		AS_FULL  = 2'd2
	} assoc_t;

	localparam logic KIND_ASSOC = 1'b0;
	localparam logic KIND_TRACK = 1'b1;

endpackage

@@ hw/rtl/nnot_mul.sv @@
// Shared registered unsigned multiplier used for all squaring.
module nnot_mul import nnot_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

@@ hw/rtl/nearest_neighbor_object_tracker_core.sv @@
// Top level of the nearest-neighbour track table: association, publishing and cleanup.
// One word at a time: in_stall is high from acceptance until the word is fully processed.
// A centroid squares the gate, then scans every slot and squares each axis difference of a
// valid entry in turn, since one registered multiplier squares the gate and every axis
// difference. A frame end adds publishing (in creation-rank order, held by any output
// stall), then timeout checks and rank compaction over every slot. Type 1 and 2 words
// take the two cleanup sweeps only. Results leave through a single output register.
module nearest_neighbor_object_tracker_core import nnot_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  pos_z,
	input  logic [PTS_W-1:0]              point_count,
	input  logic [TIME_W-1:0]             frame_time_ms,
	input  logic                          first_in_frame,
	input  logic                          last_in_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          result_kind,
	output logic [1:0]                    assoc_status,
	output logic [ID_W-1:0]               track_id,
	output logic signed [COORD_BITS-1:0]  track_x,
	output logic signed [COORD_BITS-1:0]  track_y,
	output logic signed [COORD_BITS-1:0]  track_z,
	output logic [PTS_W-1:0]              track_points,
	output logic                          last_result
);

	typedef enum logic [3:0] {
		S_IDLE, S_GATE, S_GWAIT, S_DIST, S_DECIDE, S_EMITA, S_PUB, S_RM, S_RANK
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);

	state_t state_q;

	// configuration
	logic [GATE_W-1:0] gate_q;
	logic [TIME_W-1:0] timeout_q;
	logic [PTS_W-1:0]  min_pub_q;

	// table
	logic [MAX_TRACKS-1:0]        valid_q, active_q, rm_q;
	logic [ID_W-1:0]              id_q     [MAX_TRACKS];
	logic signed [COORD_BITS-1:0] px_q     [MAX_TRACKS];
	logic signed [COORD_BITS-1:0] py_q     [MAX_TRACKS];
	logic signed [COORD_BITS-1:0] pz_q     [MAX_TRACKS];
	logic [TIME_W-1:0]            seen_q   [MAX_TRACKS];
	logic [PTS_W-1:0]             pts_q    [MAX_TRACKS];
	logic [SLOT_W-1:0]            age_q    [MAX_TRACKS];
	logic [ID_W-1:0]              next_id_q;

	// captured word
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [PTS_W-1:0]             cpts_q;
	logic [TIME_W-1:0]            now_q;
	logic                         lif_q;

	// sequencer and search state
	logic [SLOT_W-1:0] idx_q;
	logic [1:0]        ax_q;
	logic [ACC_W-1:0]  acc_q, best_q;
	logic              found_q;
	logic [SLOT_W-1:0] bidx_q, bage_q;
	logic [ID_W-1:0]   bid_q;
	assoc_t            astat_q;
	logic [ID_W-1:0]   aid_q;

	logic out_valid_q;
	logic can_load;
	assign can_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	logic accept;
	assign accept = in_valid && !in_stall;

	// ---------------- shared multiplier ----------------
	logic [MUL_W-1:0]  mul_a;
	logic [PROD_W-1:0] mul_p;
	logic signed [COORD_BITS:0] diff;
	logic signed [COORD_BITS-1:0] csel, psel;

	always_comb begin
		case (ax_q)
			2'd0: begin
				csel = cx_q;
				psel = px_q[idx_q];
			end
			2'd1: begin
				csel = cy_q;
				psel = py_q[idx_q];
			end
			default: begin
				csel = cz_q;
				psel = pz_q[idx_q];
			end
		endcase
		diff = {csel[COORD_BITS-1], csel} - {psel[COORD_BITS-1], psel};
		if (state_q == S_GATE)
			mul_a = MUL_W'(gate_q);
		else if (diff[COORD_BITS])
			mul_a = MUL_W'(unsigned'(-diff));
		else
			mul_a = MUL_W'(unsigned'(diff));
	end

	nnot_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_a),
		.p_q (mul_p)
	);

	// ---------------- table-wide views ----------------
	logic [MAX_TRACKS-1:0] elig, later_elig, pub_hit;
	logic [SLOT_W-1:0]     free_idx, hit_idx;
	logic                  any_free;
	logic [CNT_W-1:0]      used, rm_below;
	logic [ACC_W-1:0]      dsum;
	logic                  take;
	logic [TIME_W-1:0]     elapsed;

	always_comb begin
		free_idx = '0;
		hit_idx  = '0;
		used     = '0;
		rm_below = '0;
		for (int t = MAX_TRACKS - 1; t >= 0; t--) begin
			elig[t]       = valid_q[t] && active_q[t] && (pts_q[t] >= min_pub_q);
			later_elig[t] = elig[t] && (age_q[t] > idx_q);
			pub_hit[t]    = valid_q[t] && (age_q[t] == idx_q);
			if (!valid_q[t])
				free_idx = SLOT_W'(t);
			if (pub_hit[t])
				hit_idx = SLOT_W'(t);
		end
		for (int t = 0; t < MAX_TRACKS; t++) begin
			used = used + CNT_W'(valid_q[t]);
			if (rm_q[t] && (age_q[t] < age_q[idx_q]))
				rm_below = rm_below + CNT_W'(1);
		end
		any_free = !(&valid_q);
		dsum     = acc_q + ACC_W'(mul_p);
		take     = (dsum < best_q) ||
			(found_q && (dsum == best_q) &&
			 ((id_q[idx_q] < bid_q) ||
			  ((id_q[idx_q] == bid_q) && (age_q[idx_q] < bage_q))));
		elapsed  = now_q - seen_q[idx_q];
	end

	logic last_slot;
	assign last_slot = (idx_q == LAST_SLOT);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gate_q       <= GATE_RST;
			timeout_q    <= TIMEOUT_RST;
			min_pub_q    <= MIN_PUB_RST;
			valid_q      <= '0;
			active_q     <= '0;
			rm_q         <= '0;
			next_id_q    <= '0;
			idx_q        <= '0;
			ax_q         <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			result_kind  <= KIND_ASSOC;
			assoc_status <= AS_MATCH;
			track_id     <= '0;
			track_x      <= '0;
			track_y      <= '0;
			track_z      <= '0;
			track_points <= '0;
			last_result  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GATE:    gate_q    <= cfg_data[GATE_W-1:0];
					CFG_TIMEOUT: timeout_q <= cfg_data[TIME_W-1:0];
					CFG_MIN_PUB: min_pub_q <= cfg_data[PTS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rm_q  <= '0;
						idx_q <= '0;
						case (req_t'(req_type))
							REQ_CENTROID: begin
								if (first_in_frame)
									active_q <= '0;
								state_q <= S_GATE;
							end
							REQ_NO_CLUSTER: begin
								active_q <= '0;
								state_q  <= S_RM;
							end
							REQ_CLEANUP: state_q <= S_RM;
							default: ;
						endcase
					end
				end
				S_GATE: state_q <= S_GWAIT;
				S_GWAIT: begin
					found_q <= 1'b0;
					ax_q    <= '0;
					state_q <= S_DIST;
				end
				S_DIST: begin
					if (!valid_q[idx_q] || ax_q == 2'd3) begin
						ax_q <= '0;
						if (valid_q[idx_q] && take)
							found_q <= 1'b1;
						idx_q <= idx_q + SLOT_W'(1);
						if (last_slot)
							state_q <= S_DECIDE;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				S_DECIDE: begin
					if (found_q) begin
						active_q[bidx_q] <= 1'b1;
					end else if (any_free) begin
						valid_q[free_idx]  <= 1'b1;
						active_q[free_idx] <= 1'b1;
						next_id_q          <= next_id_q + ID_W'(1);
					end
					state_q <= S_EMITA;
				end
				S_EMITA: begin
					if (can_load) begin
						out_valid_q  <= 1'b1;
						result_kind  <= KIND_ASSOC;
						assoc_status <= astat_q;
						track_id     <= aid_q;
						track_x      <= cx_q;
						track_y      <= cy_q;
						track_z      <= cz_q;
						track_points <= cpts_q;
						last_result  <= !lif_q || !(|elig);
						idx_q        <= '0;
						state_q      <= lif_q ? S_PUB : S_IDLE;
					end
				end
				S_PUB: begin
					// idx_q is the creation rank here
					if (!(|pub_hit) || !elig[hit_idx] || can_load) begin
						if (|pub_hit && elig[hit_idx]) begin
							out_valid_q  <= 1'b1;
							result_kind  <= KIND_TRACK;
							assoc_status <= AS_MATCH;
							track_id     <= id_q[hit_idx];
							track_x      <= px_q[hit_idx];
							track_y      <= py_q[hit_idx];
							track_z      <= pz_q[hit_idx];
							track_points <= pts_q[hit_idx];
							last_result  <= !(|later_elig);
						end
						idx_q <= idx_q + SLOT_W'(1);
						if (last_slot)
							state_q <= S_RM;
					end
				end
				S_RM: begin
					if (valid_q[idx_q] && !active_q[idx_q] && (elapsed > timeout_q)) begin
						valid_q[idx_q] <= 1'b0;
						rm_q[idx_q]    <= 1'b1;
					end
					idx_q <= idx_q + SLOT_W'(1);
					if (last_slot)
						state_q <= S_RANK;
				end
				S_RANK: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (last_slot)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath and table payload ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q   <= pos_x;
			cy_q   <= pos_y;
			cz_q   <= pos_z;
			cpts_q <= point_count;
			now_q  <= frame_time_ms;
			lif_q  <= last_in_frame;
		end
		if (state_q == S_GWAIT) begin
			best_q <= ACC_W'(mul_p);
			acc_q  <= '0;
		end
		if (state_q == S_DIST && valid_q[idx_q]) begin
			case (ax_q)
				2'd0: ;
				2'd1: acc_q <= ACC_W'(mul_p);
				2'd2: acc_q <= dsum;
				default: begin
					acc_q <= '0;
					if (take) begin
						best_q <= dsum;
						bidx_q <= idx_q;
						bid_q  <= id_q[idx_q];
						bage_q <= age_q[idx_q];
					end
				end
			endcase
		end
		if (state_q == S_DECIDE) begin
			if (found_q) begin
				px_q[bidx_q]   <= cx_q;
				py_q[bidx_q]   <= cy_q;
				pz_q[bidx_q]   <= cz_q;
				seen_q[bidx_q] <= now_q;
				pts_q[bidx_q]  <= cpts_q;
				astat_q        <= AS_MATCH;
				aid_q          <= bid_q;
			end else if (any_free) begin
				id_q[free_idx]   <= next_id_q;
				px_q[free_idx]   <= cx_q;
				py_q[free_idx]   <= cy_q;
				pz_q[free_idx]   <= cz_q;
				seen_q[free_idx] <= now_q;
				pts_q[free_idx]  <= cpts_q;
				age_q[free_idx]  <= used[SLOT_W-1:0];
				astat_q          <= AS_NEW;
				aid_q            <= next_id_q;
			end else begin
				astat_q <= AS_FULL;
				aid_q   <= '0;
			end
		end
		// removed entries keep their rank, so survivors close the gaps against them
		if (state_q == S_RANK && valid_q[idx_q])
			age_q[idx_q] <= age_q[idx_q] - rm_below[SLOT_W-1:0];
	end

endmodule

@@ hw/rtl/nnot_checker.sv @@
// Port-level checks for the track table, bound to the top level.
module nnot_checker import nnot_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [1:0]                   req_type,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         result_kind,
	input logic [1:0]                   assoc_status,
	input logic [ID_W-1:0]              track_id,
	input logic signed [COORD_BITS-1:0] track_x,
	input logic                         last_result
);

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(track_id) && $stable(track_x)
			&& $stable(last_result))
		else $error("stalled output word changed");

	// one word at a time: busy straight after acceptance; the unused type is dropped at once
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type <= REQ_CLEANUP) |=> in_stall)
		else $error("input accepted while busy");

	a_track_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_TRACK |-> assoc_status == AS_MATCH)
		else $error("published track with non-zero status");

	a_full_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && assoc_status == AS_FULL |-> track_id == '0 && result_kind == KIND_ASSOC)
		else $error("dropped centroid carries an id");

endmodule

bind nearest_neighbor_object_tracker_core nnot_checker u_nnot_checker (.*);
